@@ design/ierd_pkg.sv @@
// input event ring device: shared types and constants
// request codes, register offsets, slot layout and the control state type
// no dependencies
package ierd_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef logic [2:0] req_t;

  localparam req_t REQ_REL_MOVE  = 3'd0;
  localparam req_t REQ_ABS_MOVE  = 3'd1;
  localparam req_t REQ_BUTTON    = 3'd2;
  localparam req_t REQ_SYNC      = 3'd3;
  localparam req_t REQ_KEY       = 3'd4;
  localparam req_t REQ_BUS_READ  = 3'd5;
  localparam req_t REQ_BUS_WRITE = 3'd6;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y = 4'd1;

  localparam int SLOT_BYTES = 16;
  localparam int SLOT_W     = SLOT_BYTES * 8;

  localparam logic [31:0] ID_WORD      = 32'h4C4F_4231;
  localparam logic [31:0] VERSION_WORD = 32'h0001_0000;

  // byte offsets on the bus
  localparam logic [9:0] REG_ID        = 10'h000;
  localparam logic [9:0] REG_VERSION   = 10'h004;
  localparam logic [9:0] REG_DEPTH     = 10'h008;
  localparam logic [9:0] REG_RD_INDEX  = 10'h00C;
  localparam logic [9:0] REG_WR_INDEX  = 10'h010;
  localparam logic [9:0] REG_SLOT_SIZE = 10'h014;
  localparam logic [9:0] REG_MODIFIERS = 10'h018;
  localparam logic [9:0] CLEAR_OFFSET  = 10'h018;
  localparam logic [9:0] SLOTS_BASE    = 10'h020;

  // key codes e0..e7 are the modifier keys
  localparam logic [4:0] MOD_KEY_PREFIX = 5'b11100;

  localparam logic [7:0] EVT_MOVE        = 8'd1;
  localparam logic [7:0] EVT_BUTTON      = 8'd2;
  localparam logic [7:0] EVT_KEY_PRESS   = 8'd3;
  localparam logic [7:0] EVT_KEY_RELEASE = 8'd4;

  localparam logic [15:0] LIMIT_X_RESET = 16'd1919;
  localparam logic [15:0] LIMIT_Y_RESET = 16'd1079;
  localparam logic [15:0] POS_X_RESET   = 16'd960;
  localparam logic [15:0] POS_Y_RESET   = 16'd540;

  localparam logic [16:0] ABS_SCALE = 17'd32767;

  // e0/e4 ctrl, e1/e5 shift, e2/e6 alt, e3/e7 gui
  function automatic logic [3:0] mod_bit(input logic [1:0] sel);
    logic [3:0] bit_mask;
    case (sel)
      2'd0:    bit_mask = 4'b0010;
      2'd1:    bit_mask = 4'b0001;
      2'd2:    bit_mask = 4'b0100;
      default: bit_mask = 4'b1000;
    endcase
    return bit_mask;
  endfunction

endpackage

@@ design/input_event_ring_device_core.sv @@
// input event ring device, top level
// ring of event slots in a synchronous memory, pointer and modifier state
// depends on ierd_pkg
//
// Each accepted transaction is handled first in the accept cycle, which
// reads the addressed slot from the ring memory and forms the absolute-move
// product, then in the execute state, which finishes the division, updates
// pointer, flag and index state and writes a new event into the ring memory.
// One transaction is in flight at a time, so a new one is taken only after
// the last leaves the execute state; a held result stalls that state. Every
// transaction gives exactly one result. Slots read as zero until first
// written (per-slot valid bits cleared by reset), so no clearing pass runs
// after reset. A bus write to 0x18 resets both ring indices.
module input_event_ring_device_core #(
  parameter int RING_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     req_type,
  input  logic                           axis,
  input  logic signed [15:0]             move_value,
  input  logic [1:0]                     button_id,
  input  logic                           pressed,
  input  logic [7:0]                     key_code,
  input  logic [9:0]                     bus_offset,
  input  logic [3:0]                     access_size,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [63:0]                    read_data,
  output logic                           event_pushed,
  output logic                           oldest_dropped,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ierd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  ierd_pkg::state_t state, state_next;

  logic in_fire, exec_fire;

  // configuration registers
  logic [15:0] limit_x, limit_y;

  // architectural state
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [IDX_W-1:0] write_index, write_index_next;
  logic [15:0]      pointer_x, pointer_x_next;
  logic [15:0]      pointer_y, pointer_y_next;
  logic [3:0]       modifier_flags, modifier_flags_next;
  logic [2:0]       button_flags, button_flags_next;

  // ring memory and slot valid bits
  logic [ierd_pkg::SLOT_W-1:0] ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0]       slot_valid;

  // captured transaction
  ierd_pkg::req_t      item_req;
  logic                item_axis;
  logic signed [15:0]  item_value;
  logic [1:0]          item_button;
  logic                item_pressed;
  logic [7:0]          item_key;
  logic [9:0]          item_offset;
  logic [3:0]          item_size;
  logic                item_slot_hit;
  logic [30:0]         abs_prod;
  logic [ierd_pkg::SLOT_W-1:0] slot_rd_data;
  logic                slot_rd_valid;

  // slot address decode on the accept side
  logic [9:0]       off_rel, slot_num;
  logic [IDX_W-1:0] slot_addr;
  logic             slot_hit;
  logic [15:0]      in_limit;

  assign off_rel   = bus_offset - ierd_pkg::SLOTS_BASE;
  assign slot_num  = off_rel >> 4;
  assign slot_addr = slot_num[IDX_W-1:0];
  assign slot_hit  = (bus_offset >= ierd_pkg::SLOTS_BASE) && (slot_num < 10'(RING_DEPTH));
  assign in_limit  = axis ? limit_y : limit_x;

  assign cfg_ready = ~rst;

  // control: next state
  always_comb begin
    state_next = state;
    case (state)
      ierd_pkg::ST_IDLE: begin
        if (in_fire) state_next = ierd_pkg::ST_EXEC;
      end
      ierd_pkg::ST_EXEC: begin
        if (exec_fire) state_next = ierd_pkg::ST_IDLE;
      end
      default: state_next = ierd_pkg::ST_IDLE;
    endcase
  end

  // control: outputs
  always_comb begin
    in_stall  = 1'b1;
    exec_fire = 1'b0;
    case (state)
      ierd_pkg::ST_IDLE: begin
        in_stall = rst;
      end
      ierd_pkg::ST_EXEC: begin
        exec_fire = ~out_valid | ~out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_fire = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ierd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_x <= ierd_pkg::LIMIT_X_RESET;
      limit_y <= ierd_pkg::LIMIT_Y_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ierd_pkg::CFG_LIMIT_X: limit_x <= cfg_data;
        ierd_pkg::CFG_LIMIT_Y: limit_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // accept stage: capture the transaction, read the slot, form the product
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_req      <= req_type;
      item_axis     <= axis;
      item_value    <= move_value;
      item_button   <= button_id;
      item_pressed  <= pressed;
      item_key      <= key_code;
      item_offset   <= bus_offset;
      item_size     <= access_size;
      item_slot_hit <= slot_hit;
      abs_prod      <= 31'(move_value[14:0]) * 31'(in_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && slot_hit) begin
      slot_rd_data <= ring_mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_rd_valid <= 1'b0;
    end else if (in_fire && slot_hit) begin
      slot_rd_valid <= slot_valid[slot_addr];
    end
  end

  // execute stage datapath
  logic [15:0] cur_pos, cur_limit, pos_top, rel_pos, abs_pos;
  logic signed [17:0] rel_sum;
  logic [15:0] abs_q0;
  logic [16:0] abs_rem;
  logic [1:0]  abs_corr;

  always_comb begin
    cur_pos   = item_axis ? pointer_y : pointer_x;
    cur_limit = item_axis ? limit_y : limit_x;
    pos_top   = (cur_limit == 16'd0) ? 16'hFFFF : cur_limit;
    rel_sum   = $signed({2'b00, cur_pos}) + 18'(item_value);
    if (rel_sum < 0) begin
      rel_pos = 16'd0;
    end else if (rel_sum[16:0] > {1'b0, pos_top}) begin
      rel_pos = pos_top;
    end else begin
      rel_pos = rel_sum[15:0];
    end
    // divide by 2^15-1: quotient estimate from the top bits, then fix up
    abs_q0  = abs_prod[30:15];
    abs_rem = 17'(abs_prod[14:0]) + 17'(abs_q0);
    if (abs_rem >= 17'(3 * ierd_pkg::ABS_SCALE)) begin
      abs_corr = 2'd3;
    end else if (abs_rem >= 17'(2 * ierd_pkg::ABS_SCALE)) begin
      abs_corr = 2'd2;
    end else if (abs_rem >= ierd_pkg::ABS_SCALE) begin
      abs_corr = 2'd1;
    end else begin
      abs_corr = 2'd0;
    end
    abs_pos = item_value[15] ? 16'd0 : abs_q0 + 16'(abs_corr);
  end

  logic push_en, drop_en, clear_en;
  logic [IDX_W-1:0] wr_inc, rd_inc;
  logic [7:0] evt_type, evt_buttons, evt_key;
  logic [15:0] evt_x, evt_y;
  logic [ierd_pkg::SLOT_W-1:0] evt_record;

  always_comb begin
    pointer_x_next      = pointer_x;
    pointer_y_next      = pointer_y;
    modifier_flags_next = modifier_flags;
    button_flags_next   = button_flags;
    push_en             = 1'b0;
    clear_en            = 1'b0;
    evt_type            = ierd_pkg::EVT_MOVE;
    case (item_req)
      ierd_pkg::REQ_REL_MOVE: begin
        if (item_axis) pointer_y_next = rel_pos;
        else pointer_x_next = rel_pos;
      end
      ierd_pkg::REQ_ABS_MOVE: begin
        if (item_axis) pointer_y_next = abs_pos;
        else pointer_x_next = abs_pos;
      end
      ierd_pkg::REQ_BUTTON: begin
        if (item_button != 2'd3) begin
          if (item_pressed) button_flags_next = button_flags | (3'b001 << item_button);
          else button_flags_next = button_flags & ~(3'b001 << item_button);
        end
        push_en  = 1'b1;
        evt_type = ierd_pkg::EVT_BUTTON;
      end
      ierd_pkg::REQ_SYNC: begin
        push_en  = 1'b1;
        evt_type = ierd_pkg::EVT_MOVE;
      end
      ierd_pkg::REQ_KEY: begin
        if (item_key != 8'd0) begin
          if (item_key[7:3] == ierd_pkg::MOD_KEY_PREFIX) begin
            if (item_pressed) begin
              modifier_flags_next = modifier_flags | ierd_pkg::mod_bit(item_key[1:0]);
            end else begin
              modifier_flags_next = modifier_flags & ~ierd_pkg::mod_bit(item_key[1:0]);
            end
          end
          push_en  = 1'b1;
          evt_type = item_pressed ? ierd_pkg::EVT_KEY_PRESS : ierd_pkg::EVT_KEY_RELEASE;
        end
      end
      ierd_pkg::REQ_BUS_WRITE: begin
        clear_en = (item_offset == ierd_pkg::CLEAR_OFFSET);
      end
      default: ;
    endcase

    // position only in move and button records
    evt_x       = (item_req == ierd_pkg::REQ_KEY) ? 16'd0 : pointer_x;
    evt_y       = (item_req == ierd_pkg::REQ_KEY) ? 16'd0 : pointer_y;
    evt_buttons = (item_req == ierd_pkg::REQ_BUTTON) ? {5'd0, button_flags_next} : 8'd0;
    evt_key     = (item_req == ierd_pkg::REQ_KEY) ? item_key : 8'd0;
    evt_record  = {32'd0, evt_key, evt_buttons, 32'd0, evt_y, evt_x,
                   {4'd0, modifier_flags_next}, evt_type};

    wr_inc  = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
    rd_inc  = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
    drop_en = push_en && (wr_inc == read_index);

    read_index_next  = read_index;
    write_index_next = write_index;
    if (clear_en) begin
      read_index_next  = '0;
      write_index_next = '0;
    end else if (push_en) begin
      write_index_next = wr_inc;
      if (drop_en) read_index_next = rd_inc;
    end
  end

  // bus read data
  logic [ierd_pkg::SLOT_W-1:0] slot_word, slot_shift;
  logic [63:0] slot_bytes, reg_data, bus_data;
  logic [3:0]  size_cap;
  logic [4:0]  room, n_bytes;
  logic        reg_hit;

  always_comb begin
    slot_word  = slot_rd_valid ? slot_rd_data : '0;
    slot_shift = slot_word >> {item_offset[3:0], 3'b000};
    size_cap   = (item_size > 4'd8) ? 4'd8 : item_size;
    room       = 5'(ierd_pkg::SLOT_BYTES) - 5'(item_offset[3:0]);
    n_bytes    = (5'(size_cap) < room) ? 5'(size_cap) : room;
    for (int i = 0; i < 8; i++) begin
      slot_bytes[i*8 +: 8] = (5'(i) < n_bytes) ? slot_shift[i*8 +: 8] : 8'h00;
    end

    reg_hit = 1'b1;
    case (item_offset)
      ierd_pkg::REG_ID:        reg_data = 64'(ierd_pkg::ID_WORD);
      ierd_pkg::REG_VERSION:   reg_data = 64'(ierd_pkg::VERSION_WORD);
      ierd_pkg::REG_DEPTH:     reg_data = 64'(RING_DEPTH);
      ierd_pkg::REG_RD_INDEX:  reg_data = 64'(read_index);
      ierd_pkg::REG_WR_INDEX:  reg_data = 64'(write_index);
      ierd_pkg::REG_SLOT_SIZE: reg_data = 64'(ierd_pkg::SLOT_BYTES);
      ierd_pkg::REG_MODIFIERS: reg_data = 64'(modifier_flags);
      default: begin
        reg_hit  = 1'b0;
        reg_data = 64'd0;
      end
    endcase

    if (item_req != ierd_pkg::REQ_BUS_READ) begin
      bus_data = 64'd0;
    end else if (reg_hit) begin
      bus_data = reg_data;
    end else if (item_slot_hit) begin
      bus_data = slot_bytes;
    end else begin
      bus_data = 64'd0;
    end
  end

  // state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index     <= '0;
      write_index    <= '0;
      pointer_x      <= ierd_pkg::POS_X_RESET;
      pointer_y      <= ierd_pkg::POS_Y_RESET;
      modifier_flags <= 4'd0;
      button_flags   <= 3'd0;
      slot_valid     <= '0;
    end else if (exec_fire) begin
      read_index     <= read_index_next;
      write_index    <= write_index_next;
      pointer_x      <= pointer_x_next;
      pointer_y      <= pointer_y_next;
      modifier_flags <= modifier_flags_next;
      button_flags   <= button_flags_next;
      if (push_en) slot_valid[write_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && push_en) begin
      ring_mem[write_index] <= evt_record;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      read_data      <= bus_data;
      event_pushed   <= push_en;
      oldest_dropped <= drop_en;
    end
  end

endmodule

@@ design/ierd_checker.sv @@
// input event ring device: port-level checks and their binding
// watches the item and result channels of the top level
// depends on input_event_ring_device_core
module ierd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] read_data,
  input logic        event_pushed,
  input logic        oldest_dropped
);

  // one transaction in flight: the cycle after an accept is always stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted while one is still in flight");

  // a drop only comes with a stored event
  a_drop_needs_push: assert property (@(posedge clk) disable iff (rst)
    out_valid && oldest_dropped |-> event_pushed)
    else $error("oldest event dropped without a push");

  // event-storing transactions never carry read data
  a_push_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_pushed |-> read_data == 64'd0)
    else $error("read data on an event transaction");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) &&
      $stable(event_pushed) && $stable(oldest_dropped))
    else $error("stalled result changed");

endmodule

bind input_event_ring_device_core ierd_checker u_ierd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .read_data      (read_data),
  .event_pushed   (event_pushed),
  .oldest_dropped (oldest_dropped)
);
